// ===== design/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg
// shared types and constants for the binary min-heap queue
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int DEPTH       = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int ADDR_WIDTH  = $clog2(DEPTH);
  localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
  localparam int OP_WIDTH    = 3;
  localparam int STAT_WIDTH  = 3;
  localparam int CAP_WIDTH   = 7;
  localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(64);
  localparam logic [KEY_WIDTH-1:0] KEY_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};

  typedef enum logic [OP_WIDTH-1:0] {
    OP_INSERT   = 3'd0,
    OP_POP      = 3'd1,
    OP_DELETE   = 3'd2,
    OP_DECREASE = 3'd3,
    OP_PEEK     = 3'd4
  } op_t;

  typedef enum logic [STAT_WIDTH-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_INDEX = 3'd4,
    ST_BAD_VALUE = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_RD,
    S_LAST_RD,
    S_UP_ISSUE,
    S_UP_CMP,
    S_DN_L,
    S_DN_LD,
    S_DN_RD,
    S_SCAN_ISSUE,
    S_SCAN_CMP,
    S_PATH_ISSUE,
    S_PATH_WR,
    S_DEC_RD,
    S_PEEK_RD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [OP_WIDTH-1:0]          op;
    logic signed [KEY_WIDTH-1:0]  key;
    logic [ADDR_WIDTH-1:0]        slot;
  } req_t;

  typedef struct packed {
    logic signed [KEY_WIDTH-1:0]  value;
    logic [STAT_WIDTH-1:0]        status;
    logic [COUNT_WIDTH-1:0]       count;
  } rsp_t;

endpackage

// ===== design/bmhq_ram.sv =====
// ----------------------------------------------------------------------------
// bmhq_ram
// generic memory, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/binary_min_heap_queue.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// array-based binary min-heap priority queue of signed keys
// ----------------------------------------------------------------------------
// usage:
//   requests arrive on in_valid/in_data; a transfer happens when in_valid is
//   high and in_stall is low. in_stall is high whenever a request is in work.
//   every request gives exactly one response on out_valid/out_data, held in
//   an output register until a transfer with out_stall low.
//   ops: insert, pop minimum, delete key, decrease at slot, peek.
//   full, empty, bad index and bad op requests go straight to the done state,
//   a peek reads the root first; the input is free again as soon as the
//   response is loaded. insert and decrease climb the tree one level at a
//   time; pop walks down one level at a time; delete scans the entries one
//   by one, moves the path up to the root, then walks down as pop does. all
//   of it is set by the single heap memory, one read and one write per
//   cycle, driven by the sequencer.
//   a new request may be taken while the last response still waits; the
//   finishing request then waits in its done state while out_stall is high.
//   cfg_wr_en/cfg_wr_data set the capacity limit; write only when idle.
//   reset (rst, synchronous) empties the heap and sets the limit to 64; the
//   memory itself is not cleared, entries beyond the count are never used.
// ----------------------------------------------------------------------------
module binary_min_heap_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bmhq_pkg::req_t                      in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bmhq_pkg::rsp_t                      out_data,
  input  logic                                cfg_wr_en,
  input  logic [bmhq_pkg::CAP_WIDTH-1:0]      cfg_wr_data
);

  localparam int AW = bmhq_pkg::ADDR_WIDTH;
  localparam int CW = bmhq_pkg::COUNT_WIDTH;
  localparam int KW = bmhq_pkg::KEY_WIDTH;

  bmhq_pkg::state_t state, state_next;

  // control registers
  logic [CW-1:0]  count, count_next;
  logic [bmhq_pkg::CAP_WIDTH-1:0] cap;
  logic [AW-1:0]  idx, idx_next;          // hole position of the moving key
  logic [AW-1:0]  scan, scan_next;        // delete scan pointer
  logic           r_ok, r_ok_next;        // right child exists
  // payload registers
  logic signed [KW-1:0] k, k_next;        // moving key / request key
  logic signed [KW-1:0] lval, lval_next;  // left child value
  logic signed [KW-1:0] value, value_next;
  logic [bmhq_pkg::STAT_WIDTH-1:0] status, status_next;
  logic [bmhq_pkg::OP_WIDTH-1:0]   op;

  // memory port
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [KW-1:0] wdata, rdata;
  logic signed [KW-1:0] rd;

  logic          accept;
  logic          full;
  logic [CW-1:0] cap_eff;
  logic [CW+1:0] lchild, rchild;
  logic [AW-1:0] parent;
  logic [AW-1:0] last_addr;
  logic          l_in, r_in;

  bmhq_ram #(
    .WIDTH (KW),
    .DEPTH (bmhq_pkg::DEPTH)
  ) u_heap (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd       = $signed(rdata);
  assign in_stall = (state != bmhq_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  // capacity clipped to the array depth
  assign cap_eff = ({1'b0, cap} > (CW+1)'(bmhq_pkg::DEPTH)) ? CW'(bmhq_pkg::DEPTH)
                                                             : CW'(cap);
  assign full    = (count >= cap_eff);

  // tree navigation
  assign lchild    = {2'b00, idx, 1'b1};
  assign rchild    = lchild + 1'b1;
  assign parent    = AW'((idx - 1'b1) >> 1);
  assign last_addr = AW'(count - 1'b1);
  assign l_in      = (lchild < {2'b00, count});
  assign r_in      = (rchild < {2'b00, count});

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bmhq_pkg::S_IDLE: begin
        if (accept) begin
          case (in_data.op)
            bmhq_pkg::OP_INSERT:   state_next = full ? bmhq_pkg::S_DONE
                                                     : bmhq_pkg::S_UP_ISSUE;
            bmhq_pkg::OP_POP:      state_next = (count == '0) ? bmhq_pkg::S_DONE
                                                              : bmhq_pkg::S_POP_RD;
            bmhq_pkg::OP_DELETE:   state_next = (count == '0) ? bmhq_pkg::S_DONE
                                                              : bmhq_pkg::S_SCAN_ISSUE;
            bmhq_pkg::OP_DECREASE: state_next = ({1'b0, in_data.slot} >= count)
                                                ? bmhq_pkg::S_DONE : bmhq_pkg::S_DEC_RD;
            bmhq_pkg::OP_PEEK:     state_next = (count == '0) ? bmhq_pkg::S_DONE
                                                              : bmhq_pkg::S_PEEK_RD;
            default:               state_next = bmhq_pkg::S_DONE;
          endcase
        end
      end
      bmhq_pkg::S_POP_RD,
      bmhq_pkg::S_PATH_ISSUE: begin
        if (state == bmhq_pkg::S_PATH_ISSUE && idx != '0) begin
          state_next = bmhq_pkg::S_PATH_WR;
        end else begin
          state_next = (count > CW'(1)) ? bmhq_pkg::S_LAST_RD : bmhq_pkg::S_DONE;
        end
      end
      bmhq_pkg::S_PATH_WR:  state_next = bmhq_pkg::S_PATH_ISSUE;
      bmhq_pkg::S_LAST_RD:  state_next = bmhq_pkg::S_DN_L;
      bmhq_pkg::S_UP_ISSUE: state_next = (idx == '0) ? bmhq_pkg::S_DONE
                                                     : bmhq_pkg::S_UP_CMP;
      bmhq_pkg::S_UP_CMP:   state_next = (rd > k) ? bmhq_pkg::S_UP_ISSUE
                                                  : bmhq_pkg::S_DONE;
      bmhq_pkg::S_DN_L:     state_next = l_in ? bmhq_pkg::S_DN_LD : bmhq_pkg::S_DONE;
      bmhq_pkg::S_DN_LD:    state_next = bmhq_pkg::S_DN_RD;
      bmhq_pkg::S_DN_RD: begin
        if ((lval < k) || (r_ok && rd < k)) begin
          state_next = bmhq_pkg::S_DN_L;
        end else begin
          state_next = bmhq_pkg::S_DONE;
        end
      end
      bmhq_pkg::S_SCAN_ISSUE: state_next = bmhq_pkg::S_SCAN_CMP;
      bmhq_pkg::S_SCAN_CMP: begin
        if (rd == k) begin
          state_next = bmhq_pkg::S_PATH_ISSUE;
        end else if ({1'b0, scan} + 1'b1 >= count) begin
          state_next = bmhq_pkg::S_DONE;
        end else begin
          state_next = bmhq_pkg::S_SCAN_ISSUE;
        end
      end
      bmhq_pkg::S_DEC_RD:  state_next = (k > rd) ? bmhq_pkg::S_DONE
                                                 : bmhq_pkg::S_UP_ISSUE;
      bmhq_pkg::S_PEEK_RD: state_next = bmhq_pkg::S_DONE;
      bmhq_pkg::S_DONE:    state_next = (!out_valid || !out_stall) ? bmhq_pkg::S_IDLE
                                                                   : bmhq_pkg::S_DONE;
      default:             state_next = bmhq_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_next  = count;
    idx_next    = idx;
    scan_next   = scan;
    r_ok_next   = r_ok;
    k_next      = k;
    lval_next   = lval;
    value_next  = value;
    status_next = status;
    we          = 1'b0;
    waddr       = idx;
    wdata       = k;
    raddr       = '0;
    case (state)
      bmhq_pkg::S_IDLE: begin
        if (accept) begin
          k_next      = in_data.key;
          idx_next    = in_data.slot;
          scan_next   = '0;
          value_next  = '0;
          status_next = bmhq_pkg::ST_OK;
          raddr       = in_data.slot;   // decrease reads its slot, pop and peek the root
          case (in_data.op)
            bmhq_pkg::OP_INSERT: begin
              if (full) begin
                status_next = bmhq_pkg::ST_FULL;
              end else begin
                idx_next   = AW'(count);
                count_next = count + 1'b1;
              end
            end
            bmhq_pkg::OP_POP,
            bmhq_pkg::OP_PEEK: begin
              raddr = '0;
              if (count == '0) begin
                value_next  = bmhq_pkg::KEY_MAX;
                status_next = bmhq_pkg::ST_EMPTY;
              end
            end
            bmhq_pkg::OP_DELETE: begin
              if (count == '0) begin
                status_next = bmhq_pkg::ST_NOT_FOUND;
              end
            end
            bmhq_pkg::OP_DECREASE: begin
              if ({1'b0, in_data.slot} >= count) begin
                status_next = bmhq_pkg::ST_BAD_INDEX;
              end
            end
            default: status_next = bmhq_pkg::ST_BAD_VALUE;
          endcase
        end
      end
      bmhq_pkg::S_POP_RD,
      bmhq_pkg::S_PATH_ISSUE: begin
        if (state == bmhq_pkg::S_PATH_ISSUE && idx != '0) begin
          raddr = parent;
        end else begin
          if (state == bmhq_pkg::S_POP_RD) begin
            value_next = rd;
          end
          // last entry becomes the new root
          raddr      = last_addr;
          count_next = count - 1'b1;
        end
      end
      bmhq_pkg::S_PATH_WR: begin
        // push the ancestor down into the hole
        we       = 1'b1;
        wdata    = rdata;
        idx_next = parent;
      end
      bmhq_pkg::S_LAST_RD: begin
        k_next   = rd;
        idx_next = '0;
      end
      bmhq_pkg::S_UP_ISSUE: begin
        raddr = parent;
        if (idx == '0) begin
          we = 1'b1;
        end
      end
      bmhq_pkg::S_UP_CMP: begin
        we = 1'b1;
        if (rd > k) begin
          wdata    = rdata;
          idx_next = parent;
        end
      end
      bmhq_pkg::S_DN_L: begin
        raddr = lchild[AW-1:0];
        if (!l_in) begin
          we = 1'b1;
        end
      end
      bmhq_pkg::S_DN_LD: begin
        lval_next = rd;
        r_ok_next = r_in;
        raddr     = rchild[AW-1:0];
      end
      bmhq_pkg::S_DN_RD: begin
        we = 1'b1;
        // smaller child wins, left on a tie
        if (r_ok && rd < k && !(lval <= rd)) begin
          wdata    = rdata;
          idx_next = rchild[AW-1:0];
        end else if (lval < k) begin
          wdata    = lval;
          idx_next = lchild[AW-1:0];
        end else if (r_ok && rd < k) begin
          wdata    = rdata;
          idx_next = rchild[AW-1:0];
        end
      end
      bmhq_pkg::S_SCAN_ISSUE: begin
        raddr = scan;
      end
      bmhq_pkg::S_SCAN_CMP: begin
        if (rd == k) begin
          idx_next = scan;
        end else begin
          scan_next = scan + 1'b1;
          if ({1'b0, scan} + 1'b1 >= count) begin
            status_next = bmhq_pkg::ST_NOT_FOUND;
          end
        end
      end
      bmhq_pkg::S_DEC_RD: begin
        if (k > rd) begin
          status_next = bmhq_pkg::ST_BAD_VALUE;
        end
      end
      bmhq_pkg::S_PEEK_RD: begin
        value_next = rd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bmhq_pkg::S_IDLE;
      count     <= '0;
      cap       <= bmhq_pkg::CAP_RESET;
      out_valid <= 1'b0;
      r_ok      <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      r_ok  <= r_ok_next;
      if (cfg_wr_en) begin
        cap <= cfg_wr_data;
      end
      if (state == bmhq_pkg::S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    scan   <= scan_next;
    k      <= k_next;
    lval   <= lval_next;
    value  <= value_next;
    status <= status_next;
    if (accept) begin
      op <= in_data.op;
    end
    if (state == bmhq_pkg::S_DONE && (!out_valid || !out_stall)) begin
      // every op but pop and peek reports value zero
      out_data.value  <= (op == bmhq_pkg::OP_POP || op == bmhq_pkg::OP_PEEK) ? value : '0;
      out_data.status <= status;
      out_data.count  <= count;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the binary min-heap queue: a local heap predictor
// produces the expected response of every request, a monitor compares each
// response transfer field by field, and named tests cover directed corners,
// capacity settings, output back-pressure and a long random mix
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 400;
  localparam int KW = bmhq_pkg::KEY_WIDTH;
  localparam int AW = bmhq_pkg::ADDR_WIDTH;
  localparam int OW = bmhq_pkg::OP_WIDTH;
  localparam int PW = bmhq_pkg::CAP_WIDTH;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  bmhq_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bmhq_pkg::rsp_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [PW-1:0] cfg_wr_data = '0;

  binary_min_heap_queue dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  // predictor state: mirror of the heap array, live count and limit
  logic signed [KW-1:0] mirror_heap [bmhq_pkg::DEPTH];
  int unsigned mirror_count;
  int unsigned mirror_cap;
  bmhq_pkg::rsp_t expected_rsp_q[$];
  int error_count = 0;

  // idling controls
  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  bit hold_request = 1'b0;

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic signed [KW-1:0] t;
    t = mirror_heap[a];
    mirror_heap[a] = mirror_heap[b];
    mirror_heap[b] = t;
  endfunction

  function automatic void climb(int unsigned i);
    while (i != 0 && mirror_heap[(i-1)/2] > mirror_heap[i]) begin
      swap_entries(i, (i-1)/2);
      i = (i-1)/2;
    end
  endfunction

  function automatic logic signed [KW-1:0] take_root();
    logic signed [KW-1:0] root;
    int unsigned i, l, r, m;
    root = mirror_heap[0];
    mirror_count--;
    if (mirror_count > 0) begin
      mirror_heap[0] = mirror_heap[mirror_count];
      i = 0;
      forever begin
        l = 2*i+1; r = 2*i+2; m = i;
        if (l < mirror_count && mirror_heap[l] < mirror_heap[m]) m = l;
        if (r < mirror_count && mirror_heap[r] < mirror_heap[m]) m = r;
        if (m == i) break;
        swap_entries(i, m);
        i = m;
      end
    end
    return root;
  endfunction

  // expected response of one request, updating the mirror
  function automatic bmhq_pkg::rsp_t heap_response(bmhq_pkg::req_t rq);
    bmhq_pkg::rsp_t rs;
    int unsigned cap, i;
    rs = '0;
    rs.status = bmhq_pkg::ST_OK;
    cap = (mirror_cap > bmhq_pkg::DEPTH) ? bmhq_pkg::DEPTH : mirror_cap;
    case (rq.op)
      bmhq_pkg::OP_INSERT: begin
        if (mirror_count >= cap) rs.status = bmhq_pkg::ST_FULL;
        else begin
          mirror_heap[mirror_count] = rq.key;
          mirror_count++;
          climb(mirror_count - 1);
        end
      end
      bmhq_pkg::OP_POP, bmhq_pkg::OP_PEEK: begin
        if (mirror_count == 0) begin
          rs.value = bmhq_pkg::KEY_MAX;
          rs.status = bmhq_pkg::ST_EMPTY;
        end else if (rq.op == bmhq_pkg::OP_POP) rs.value = take_root();
        else rs.value = mirror_heap[0];
      end
      bmhq_pkg::OP_DELETE: begin
        rs.status = bmhq_pkg::ST_NOT_FOUND;
        for (i = 0; i < mirror_count; i++) begin
          if (mirror_heap[i] == rq.key) begin
            while (i != 0) begin
              swap_entries(i, (i-1)/2);
              i = (i-1)/2;
            end
            void'(take_root());
            rs.status = bmhq_pkg::ST_OK;
            break;
          end
        end
      end
      bmhq_pkg::OP_DECREASE: begin
        if (rq.slot >= mirror_count) rs.status = bmhq_pkg::ST_BAD_INDEX;
        else if (rq.key > mirror_heap[rq.slot]) rs.status = bmhq_pkg::ST_BAD_VALUE;
        else begin
          mirror_heap[rq.slot] = rq.key;
          climb(rq.slot);
        end
      end
      default: rs.status = bmhq_pkg::ST_BAD_VALUE;
    endcase
    rs.count = bmhq_pkg::COUNT_WIDTH'(mirror_count);
    return rs;
  endfunction

  // sends one request; prediction is made at the transfer edge
  task automatic send_request(input logic [OW-1:0] op,
                              input logic signed [KW-1:0] key,
                              input logic [AW-1:0] slot);
    int gap;
    if (send_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{op: op, key: key, slot: slot};
    do @(posedge clk); while (in_stall);
    expected_rsp_q.push_back(heap_response(in_data));
    @(negedge clk);
  endtask

  // response transfer check
  always @(posedge clk) begin
    bmhq_pkg::rsp_t exp_rsp;
    if (!rst && out_valid && !out_stall) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: unexpected response %h", $time, out_data);
        error_count++;
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        if (out_data.value !== exp_rsp.value) begin
          $display("%0t: value expected %0d actual %0d", $time,
                   exp_rsp.value, out_data.value);
          error_count++;
        end
        if (out_data.status !== exp_rsp.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_rsp.status, out_data.status);
          error_count++;
        end
        if (out_data.count !== exp_rsp.count) begin
          $display("%0t: count expected %0d actual %0d", $time,
                   exp_rsp.count, out_data.count);
          error_count++;
        end
      end
    end
  end

  // receiver: random stall bursts, plus a long counted hold-off on request
  always @(negedge clk) begin
    int n;
    if (hold_request) begin
      out_stall <= 1'b1;
      for (n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
      hold_request = 1'b0;
      out_stall <= 1'b0;
    end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      n = $urandom_range(1, 19);
      repeat (n) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  // wait until every response transfer has happened, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [PW-1:0] cap);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    mirror_cap = cap;
  endtask

  function automatic logic signed [KW-1:0] random_key(bit narrow);
    if (narrow) return $signed(32'($urandom_range(0, 40))) - 20;
    return $signed($urandom);
  endfunction

  // a key that is live in the mirror, if any
  function automatic logic signed [KW-1:0] live_key();
    if (mirror_count == 0) return random_key(1'b1);
    return mirror_heap[$urandom_range(0, mirror_count - 1)];
  endfunction

  task automatic test_directed();
    send_request(bmhq_pkg::OP_POP, 0, 0);
    send_request(bmhq_pkg::OP_PEEK, 0, 0);
    send_request(bmhq_pkg::OP_DELETE, 5, 0);
    send_request(bmhq_pkg::OP_DECREASE, 0, 0);
    send_request(bmhq_pkg::OP_INSERT, 32'sh7fffffff, 0);
    send_request(bmhq_pkg::OP_INSERT, 32'sh80000000, 0);
    send_request(bmhq_pkg::OP_INSERT, 0, 0);
    send_request(bmhq_pkg::OP_INSERT, -1, 0);
    send_request(bmhq_pkg::OP_PEEK, 0, 0);
    send_request(bmhq_pkg::OP_DECREASE, 32'sh7fffffff, 1);
    send_request(bmhq_pkg::OP_DECREASE, 32'sh80000000, 3);
    send_request(bmhq_pkg::OP_DECREASE, -1, 63);
    send_request(bmhq_pkg::OP_DECREASE, live_key(), 2);
    send_request(bmhq_pkg::OP_DELETE, 0, 0);
    send_request(bmhq_pkg::OP_DELETE, 1234, 0);
    send_request(3'd5, 0, 0);
    send_request(3'd6, -1, 63);
    send_request(3'd7, 32'sh55555555, 42);
    send_request(bmhq_pkg::OP_POP, 0, 0);
    send_request(bmhq_pkg::OP_POP, 0, 0);
    send_request(bmhq_pkg::OP_POP, 0, 0);
    send_request(bmhq_pkg::OP_POP, 0, 0);
  endtask

  // fill up to the limit, overflow, then empty again
  task automatic test_capacity(input logic [PW-1:0] cap);
    int k;
    write_capacity(cap);
    for (k = 0; k < 70 && k < cap + 3; k++)
      send_request(bmhq_pkg::OP_INSERT, random_key(bit'(k & 1)), 0);
    while (mirror_count > 0) send_request(bmhq_pkg::OP_POP, 0, 0);
    send_request(bmhq_pkg::OP_POP, 0, 0);
  endtask

  // limit lowered below the live count: entries stay, inserts are refused until deletes bring the count below it
  task automatic test_lowered_limit();
    int k;
    write_capacity(7'd64);
    for (k = 0; k < 20; k++) send_request(bmhq_pkg::OP_INSERT, random_key(1'b0), 0);
    write_capacity(7'd5);
    send_request(bmhq_pkg::OP_INSERT, 1, 0);
    while (mirror_count > 4) send_request(bmhq_pkg::OP_DELETE, live_key(), 0);
    send_request(bmhq_pkg::OP_INSERT, 2, 0);
    send_request(bmhq_pkg::OP_INSERT, 3, 0);
    while (mirror_count > 0) send_request(bmhq_pkg::OP_POP, 0, 0);
  endtask

  // long receiver hold-off while requests keep coming
  task automatic test_backpressure();
    int k;
    write_capacity(7'd64);
    hold_request = 1'b1;
    for (k = 0; k < 30; k++) send_request(bmhq_pkg::OP_INSERT, random_key(1'b0), 0);
    for (k = 0; k < 30; k++) send_request(bmhq_pkg::OP_POP, 0, 0);
  endtask

  task automatic random_request(bit narrow);
    int sel;
    logic [AW-1:0] s;
    sel = $urandom_range(0, 99);
    s = (mirror_count > 0 && sel % 4 != 0) ?
        AW'($urandom_range(0, mirror_count - 1)) : AW'($urandom);
    if (sel < 35) send_request(bmhq_pkg::OP_INSERT, random_key(narrow), s);
    else if (sel < 55) send_request(bmhq_pkg::OP_POP, random_key(narrow), s);
    else if (sel < 68) send_request(bmhq_pkg::OP_DELETE,
        (sel & 1) ? live_key() : random_key(narrow), s);
    else if (sel < 83) send_request(bmhq_pkg::OP_DECREASE,
        (sel & 1) ? live_key() - $signed(32'($urandom_range(0, 50))) : random_key(narrow), s);
    else if (sel < 95) send_request(bmhq_pkg::OP_PEEK, random_key(narrow), s);
    else send_request(OW'($urandom_range(5, 7)), random_key(narrow), s);
  endtask

  task automatic test_random(input int n);
    int k;
    for (k = 0; k < n; k++) random_request(k % 3 == 0);
  endtask

  initial begin
    mirror_count = 0;
    mirror_cap = bmhq_pkg::CAP_RESET;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_capacity(7'd0);
    test_capacity(7'd1);
    test_capacity(7'd127);
    test_lowered_limit();
    test_backpressure();
    write_capacity(7'd64);
    test_random(600);
    write_capacity(7'd10);
    test_random(300);
    write_capacity(7'(($urandom_range(1, 63))));
    test_random(300);
    write_capacity(7'd100);
    // last stretch with no idling on either side
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    test_random(300);
    drain();
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
